>>> hw/rtl/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Shared constants, types and sequencer states of the tick priority scheduler.
// ----------------------------------------------------------------------------
package tps_pkg;

    localparam int TASK_COUNT = 16;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 4;
    localparam int PRIO_W     = 64;
    localparam int ADDR_W     = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ADDR_W-1:0] t_addr;

    localparam t_idx IDLE_TASK = t_idx'(0);
    localparam t_idx FIRST_IDX = t_idx'(1);
    localparam t_idx LAST_IDX  = t_idx'(TASK_COUNT - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_RELOAD,
        S_DONE
    } t_state;

    // Access to the counter store: one write and one read address.
    typedef struct packed {
        logic  wr_en;
        t_addr wr_addr;
        t_cnt  wr_data;
        t_addr rd_addr;
    } t_mem_req;

endpackage

>>> hw/rtl/tps_cnt_mem.sv
// ----------------------------------------------------------------------------
// tps_cnt_mem
// Remaining-time counter store: one write and one registered read per cycle,
// with a valid bit per entry so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
module tps_cnt_mem (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tps_pkg::t_mem_req i_req,
    output tps_pkg::t_cnt    o_rd_cnt
);
    import tps_pkg::*;

    t_cnt                  r_mem [TASK_COUNT];
    logic [TASK_COUNT-1:0] r_valid;
    t_cnt                  r_rd_data;
    logic                  r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= r_mem[i_req.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_req.rd_addr];
        end
    end

    assign o_rd_cnt = r_rd_valid ? r_rd_data : '0;

endmodule

>>> hw/rtl/tick_priority_task_scheduler_top.sv
// ----------------------------------------------------------------------------
// tick_priority_task_scheduler_top
// When the running task keeps the CPU or the tick bit is 0, no scan runs.
// A scheduling pass scans one task per cycle through one compare unit and
// the single counter read port; a pass with refill adds S_RELOAD and a
// second scan. One tick in flight at a time. Synchronous active-low reset
// clears all counters, the priorities and the running task (idle).
// ----------------------------------------------------------------------------
module tick_priority_task_scheduler_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_tick_valid,
    output logic                  o_tick_ready,
    input  logic                  i_tick,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [tps_pkg::PRIO_W-1:0] i_task_priorities,
    output logic                  o_result_valid,
    input  logic                  i_result_ready,
    output logic                  o_switched,
    output tps_pkg::t_idx         o_task_id,
    output tps_pkg::t_cnt         o_remaining,
    output logic                  o_reloaded,
    output logic                  o_none_ready
);
    import tps_pkg::*;

    t_state r_state, n_state;

    logic [PRIO_W-1:0] r_prio;
    t_idx   r_cur, r_prev, r_idx, r_pend_idx, r_best;
    t_cnt   r_run_cnt, r_best_cnt;
    logic   r_pend, r_rel, r_none;

    logic   r_out_valid, r_out_switched, r_out_reloaded, r_out_none;
    t_idx   r_out_task;
    t_cnt   r_out_remaining;

    t_mem_req mem_req;
    t_cnt     rd_cnt;
    logic     tick_xfer, keep_run, out_free, cmp_take;
    t_idx     n_best;
    t_cnt     n_best_cnt, prio_nib;

    tps_cnt_mem u_cnt_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mem_req),
        .o_rd_cnt (rd_cnt)
    );

    assign tick_xfer = i_tick_valid && o_tick_ready;
    assign keep_run  = i_tick && (r_cur != IDLE_TASK) && (r_run_cnt != '0);
    assign out_free  = !r_out_valid || i_result_ready;

    // shared compare unit: largest nonzero counter, ties to the higher index
    assign cmp_take   = r_pend && (rd_cnt != '0) && (rd_cnt >= r_best_cnt);
    assign n_best     = cmp_take ? r_pend_idx : r_best;
    assign n_best_cnt = cmp_take ? rd_cnt : r_best_cnt;

    assign prio_nib = r_prio[{r_idx, 2'b00} +: CNT_W];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (tick_xfer) begin
                    n_state = (i_tick && !keep_run) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                n_state = (n_best == IDLE_TASK && !r_rel) ? S_RELOAD : S_DONE;
            end
            S_RELOAD: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_SCAN;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_tick_ready    = 1'b0;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = r_cur[ADDR_W-1:0];
        mem_req.wr_data = r_run_cnt - t_cnt'(1);
        mem_req.rd_addr = r_idx[ADDR_W-1:0];
        case (r_state)
            S_IDLE: begin
                o_tick_ready  = 1'b1;
                mem_req.wr_en = tick_xfer && keep_run;
            end
            S_SCAN_END: begin
                mem_req.wr_en   = (n_best != IDLE_TASK) && (n_best != r_cur);
                mem_req.wr_addr = n_best[ADDR_W-1:0];
                mem_req.wr_data = n_best_cnt - t_cnt'(1);
            end
            S_RELOAD: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_idx[ADDR_W-1:0];
                mem_req.wr_data = prio_nib;
            end
            default: begin
            end
        endcase
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prio      <= '0;
            r_cur       <= IDLE_TASK;
            r_prev      <= IDLE_TASK;
            r_run_cnt   <= '0;
            r_idx       <= FIRST_IDX;
            r_pend      <= 1'b0;
            r_pend_idx  <= IDLE_TASK;
            r_best      <= IDLE_TASK;
            r_best_cnt  <= '0;
            r_rel       <= 1'b0;
            r_none      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_prio <= i_task_priorities;
            end
            r_pend     <= (r_state == S_SCAN);
            r_pend_idx <= r_idx;
            // transfer the result once the output slot is free
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_result_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (tick_xfer) begin
                        r_prev     <= r_cur;
                        r_rel      <= 1'b0;
                        r_none     <= 1'b0;
                        r_idx      <= FIRST_IDX;
                        r_best     <= IDLE_TASK;
                        r_best_cnt <= '0;
                        if (keep_run) begin
                            r_run_cnt <= r_run_cnt - t_cnt'(1);
                        end
                    end
                end
                S_SCAN: begin
                    r_best     <= n_best;
                    r_best_cnt <= n_best_cnt;
                    r_idx      <= r_idx + t_idx'(1);
                end
                S_SCAN_END: begin
                    r_idx <= FIRST_IDX;
                    if (n_best == IDLE_TASK) begin
                        if (r_rel) begin
                            r_none    <= 1'b1;
                            r_cur     <= IDLE_TASK;
                            r_run_cnt <= '0;
                        end
                    end else if (n_best != r_cur) begin
                        r_cur     <= n_best;
                        r_run_cnt <= n_best_cnt - t_cnt'(1);
                    end else begin
                        r_run_cnt <= n_best_cnt;
                    end
                end
                S_RELOAD: begin
                    if (r_idx == LAST_IDX) begin
                        r_idx      <= FIRST_IDX;
                        r_rel      <= 1'b1;
                        r_best     <= IDLE_TASK;
                        r_best_cnt <= '0;
                    end else begin
                        r_idx <= r_idx + t_idx'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_switched  <= (r_cur != r_prev);
            r_out_task      <= r_cur;
            r_out_remaining <= r_run_cnt;
            r_out_reloaded  <= r_rel;
            r_out_none      <= r_none;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_switched     = r_out_switched;
    assign o_task_id      = r_out_task;
    assign o_remaining    = r_out_remaining;
    assign o_reloaded     = r_out_reloaded;
    assign o_none_ready   = r_out_none;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the tick priority scheduler against a cycle-free scheduling model:
// ticks go in over valid/ready, each result is compared field by field with
// the predicted one, under several priority settings and idling patterns.
// ----------------------------------------------------------------------------
module testbench;

    import tps_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int NUM_PHASES     = 8;
    localparam int TICKS_PER_PHASE = 93;

    typedef struct packed {
        logic switched;
        t_idx task_id;
        t_cnt remaining;
        logic reloaded;
        logic none_ready;
    } t_sched_out;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_tick_valid = 1'b0;
    logic              o_tick_ready;
    logic              i_tick = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [PRIO_W-1:0] i_task_priorities = '0;
    logic              o_result_valid;
    logic              i_result_ready = 1'b0;
    logic              o_switched;
    t_idx              o_task_id;
    t_cnt              o_remaining;
    logic              o_reloaded;
    logic              o_none_ready;

    // Scheduler model state
    logic [PRIO_W-1:0] prio_cfg;
    t_cnt              slice_left [TASK_COUNT];
    t_idx              cur_task;

    logic       tick_q [$];
    t_sched_out expected_q [$];

    bit tick_xfer;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_queued   = 0;
    int results_seen   = 0;
    int err_cnt        = 0;
    int idle_cycles    = 0;
    int cfg_writes     = 0;
    int switch_cnt     = 0;
    int refill_cnt     = 0;
    int no_task_cnt    = 0;

    tick_priority_task_scheduler_top i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_tick_valid      (i_tick_valid),
        .o_tick_ready      (o_tick_ready),
        .i_tick            (i_tick),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_task_priorities (i_task_priorities),
        .o_result_valid    (o_result_valid),
        .i_result_ready    (i_result_ready),
        .o_switched        (o_switched),
        .o_task_id         (o_task_id),
        .o_remaining       (o_remaining),
        .o_reloaded        (o_reloaded),
        .o_none_ready      (o_none_ready)
    );

    always #5 i_clk = ~i_clk;

    // Largest nonzero slice wins, ties go to the higher index.
    function automatic t_idx pick_ready_task();
        t_idx best;
        t_cnt best_cnt;
        best     = IDLE_TASK;
        best_cnt = '0;
        for (int i = 1; i < TASK_COUNT; i++) begin
            if (slice_left[i] != '0 && slice_left[i] >= best_cnt) begin
                best_cnt = slice_left[i];
                best     = t_idx'(i);
            end
        end
        return best;
    endfunction

    function automatic t_sched_out schedule_tick(input logic tick_bit);
        t_idx       prev;
        t_idx       nxt;
        t_sched_out r;
        prev         = cur_task;
        r.reloaded   = 1'b0;
        r.none_ready = 1'b0;
        if (tick_bit) begin
            if (cur_task != IDLE_TASK && slice_left[cur_task] != '0) begin
                slice_left[cur_task] = slice_left[cur_task] - 1'b1;
            end else begin
                nxt = pick_ready_task();
                if (nxt == IDLE_TASK) begin
                    for (int i = 1; i < TASK_COUNT; i++)
                        slice_left[i] = prio_cfg[4*i +: 4];
                    r.reloaded = 1'b1;
                    nxt = pick_ready_task();
                end
                if (nxt == IDLE_TASK) begin
                    r.none_ready = 1'b1;
                    cur_task     = IDLE_TASK;
                end else if (nxt != cur_task) begin
                    // A task picked again after a refill keeps its full slice.
                    slice_left[nxt] = slice_left[nxt] - 1'b1;
                    cur_task        = nxt;
                end
            end
        end
        r.switched  = (cur_task != prev);
        r.task_id   = cur_task;
        r.remaining = (cur_task == IDLE_TASK) ? t_cnt'(0) : slice_left[cur_task];
        return r;
    endfunction

    // Tick and result-ready driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_tick_valid   <= 1'b0;
            i_tick         <= 1'b0;
            i_result_ready <= 1'b0;
        end else begin
            if (!i_tick_valid || tick_xfer) begin
                if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_tick_valid <= 1'b1;
                    i_tick       <= tick_q.pop_front();
                end else begin
                    i_tick_valid <= 1'b0;
                    i_tick       <= 1'($urandom);
                end
            end
            i_result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on tick transfer, check on result transfer
    always @(posedge i_clk) begin
        t_sched_out exp_r;
        bit         res_xfer;
        bit         cfg_xfer;
        if (!i_rst_n) begin
            prio_cfg  = '0;
            cur_task  = IDLE_TASK;
            for (int i = 0; i < TASK_COUNT; i++)
                slice_left[i] = '0;
            expected_q.delete();
            tick_xfer   = 1'b0;
            idle_cycles = 0;
        end else begin
            tick_xfer = i_tick_valid && o_tick_ready;
            cfg_xfer  = i_cfg_valid && o_cfg_ready;
            res_xfer  = o_result_valid && i_result_ready;
            if (cfg_xfer)
                prio_cfg = i_task_priorities;
            if (tick_xfer)
                expected_q.push_back(schedule_tick(i_tick));
            if (res_xfer) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    $error("result with no tick outstanding: task_id %0d", o_task_id);
                    err_cnt++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (o_switched !== exp_r.switched) begin
                        $error("switched: expected %0d, actual %0d",
                               exp_r.switched, o_switched);
                        err_cnt++;
                    end
                    if (o_task_id !== exp_r.task_id) begin
                        $error("task_id: expected %0d, actual %0d",
                               exp_r.task_id, o_task_id);
                        err_cnt++;
                    end
                    if (o_remaining !== exp_r.remaining) begin
                        $error("remaining: expected %0d, actual %0d",
                               exp_r.remaining, o_remaining);
                        err_cnt++;
                    end
                    if (o_reloaded !== exp_r.reloaded) begin
                        $error("reloaded: expected %0d, actual %0d",
                               exp_r.reloaded, o_reloaded);
                        err_cnt++;
                    end
                    if (o_none_ready !== exp_r.none_ready) begin
                        $error("none_ready: expected %0d, actual %0d",
                               exp_r.none_ready, o_none_ready);
                        err_cnt++;
                    end
                    switch_cnt  += exp_r.switched;
                    refill_cnt  += exp_r.reloaded;
                    no_task_cnt += exp_r.none_ready;
                end
            end
            if (tick_xfer || cfg_xfer || res_xfer)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("[tick_priority_task_scheduler_top] ERROR");
                $finish;
            end
        end
    end

    task automatic queue_tick(input logic tick_bit);
        tick_q.push_back(tick_bit);
        items_queued++;
    endtask

    task automatic wait_drained();
        while (results_seen != items_queued)
            @(negedge i_clk);
    endtask

    // Write only while nothing is in flight.
    task automatic write_priorities(input logic [PRIO_W-1:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_task_priorities <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid       <= 1'b0;
        i_task_priorities <= {$urandom, $urandom};
        cfg_writes++;
    endtask

    function automatic logic [PRIO_W-1:0] sparse_priorities();
        logic [PRIO_W-1:0] v;
        v = '0;
        for (int i = 0; i < 16; i++)
            if ($urandom_range(2) == 0)
                v[4*i +: 4] = 4'($urandom_range(3, 1));
        return v;
    endfunction

    initial begin
        logic [PRIO_W-1:0] prio;
        int                ones;
        int                pick;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset priorities, ignored nibble 0, one task, all zero, all max
        queue_tick(1'b1);
        queue_tick(1'b1);
        queue_tick(1'b0);
        write_priorities(64'h0000_0000_0000_000F);
        queue_tick(1'b1);
        queue_tick(1'b1);
        write_priorities(64'h0000_0000_0000_0020);
        queue_tick(1'b1);
        queue_tick(1'b1);
        queue_tick(1'b1);
        queue_tick(1'b0);
        queue_tick(1'b1);
        queue_tick(1'b1);
        // drop the running task's priority: fall back to idle with a switch
        write_priorities('0);
        queue_tick(1'b1);
        queue_tick(1'b1);
        write_priorities('1);
        queue_tick(1'b1);
        queue_tick(1'b1);
        queue_tick(1'b0);
        queue_tick(1'b1);
        // priorities that tie tasks 1 and 3; these ticks still run task 15 on its old slice
        write_priorities(64'h0000_0000_0000_5A50);
        repeat (5) queue_tick(1'b1);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            pick = ph;
            case (pick)
                0:       prio = '1;
                1, 5:    prio = {$urandom, $urandom};
                2, 6:    prio = sparse_priorities();
                3:       prio = '0;
                4: begin
                    prio = '0;
                    prio[4*$urandom_range(TASK_COUNT-1, 1) +: 4] = 4'($urandom_range(15, 1));
                end
                default: prio = 64'hFFFF_FFFF_FFFF_FFF0;
            endcase
            write_priorities(prio);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            ones = 0;
            while (ones < TICKS_PER_PHASE) begin
                if ($urandom_range(9) == 0) begin
                    queue_tick(1'b0);
                end else begin
                    queue_tick(1'b1);
                    ones++;
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_q.size() != 0) begin
            $error("%0d results never arrived", expected_q.size());
            err_cnt++;
        end
        $display("Checked %0d results across %0d priority writes and four idling patterns.",
                 results_seen, cfg_writes);
        $display("Seen: %0d task switches, %0d refills, %0d ticks with no task ready.",
                 switch_cnt, refill_cnt, no_task_cnt);
        if (err_cnt == 0)
            $display("[tick_priority_task_scheduler_top] OK");
        else
            $display("[tick_priority_task_scheduler_top] ERROR");
        $finish;
    end

endmodule
